FILE: sv/php_pkg.sv
// ----------------------------------------------------------------------------
// php_pkg
// Types and constants shared by the packet header parser modules.
// ----------------------------------------------------------------------------
package php_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } php_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  packet_tag;
        logic [31:0] packet_length;
        logic        has_length;
    } php_out_t;

    // One queue entry: a finished result, with the two-byte length form still
    // waiting for its bias to be added by the back end.
    typedef struct packed {
        php_out_t res;
        logic     two_byte;
    } php_entry_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT,
        PH_NEW_FIRST,
        PH_NEW_SECOND
    } php_phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EOS       = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_UNHANDLED = 2'd3;

    localparam logic [1:0] LT_ONE_BYTE       = 2'd0;
    localparam logic [1:0] LT_TWO_BYTE       = 2'd1;
    localparam logic [1:0] LT_INDETERMINATE  = 2'd3;

    localparam logic [7:0]  LEN_TWO_BYTE_MIN  = 8'd192;
    localparam logic [7:0]  LEN_TWO_BYTE_MAX  = 8'd223;
    localparam logic [7:0]  LEN_FOUR_BYTE     = 8'd255;
    localparam logic [31:0] LEN_TWO_BYTE_BIAS = 32'd192;

endpackage

FILE: sv/php_front.sv
// ----------------------------------------------------------------------------
// php_front
// Header byte state machine: accepts stream bytes and queues finished results.
// ----------------------------------------------------------------------------
module php_front
    import php_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  php_in_t    in_item,
    output logic       q_push,
    output php_entry_t q_entry
);

    php_phase_t  phase_reg, phase_next;
    logic [2:0]  rem_reg, rem_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  tag_reg, tag_next;

    logic [7:0]  b;
    logic [31:0] acc_shift;
    logic [2:0]  rem_dec;

    assign b         = in_item.data_byte;
    assign acc_shift = {acc_reg[23:0], b};
    assign rem_dec   = (rem_reg != 3'd0) ? rem_reg - 3'd1 : 3'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rem_reg   <= '0;
            acc_reg   <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            tag_reg   <= tag_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        tag_next   = tag_reg;
        q_push     = 1'b0;
        q_entry    = '0;

        if (accept)
        begin
            if (in_item.end_of_stream)
            begin
                q_push                 = 1'b1;
                q_entry.res.status     = ST_EOS;
                q_entry.res.packet_tag = (phase_reg == PH_IDLE) ? 6'd0 : tag_reg;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (!b[7])
                        begin
                            q_push             = 1'b1;
                            q_entry.res.status = ST_INVALID;
                        end
                        else
                        begin
                            acc_next = '0;
                            if (!b[6])
                            begin
                                tag_next = {2'b00, b[5:2]};
                                if (b[1:0] == LT_INDETERMINATE)
                                begin
                                    q_push                 = 1'b1;
                                    q_entry.res.status     = ST_OK;
                                    q_entry.res.packet_tag = {2'b00, b[5:2]};
                                end
                                else
                                begin
                                    if (b[1:0] == LT_ONE_BYTE)
                                        rem_next = 3'd1;
                                    else if (b[1:0] == LT_TWO_BYTE)
                                        rem_next = 3'd2;
                                    else
                                        rem_next = 3'd4;
                                    phase_next = PH_COLLECT;
                                end
                            end
                            else
                            begin
                                tag_next   = b[5:0];
                                phase_next = PH_NEW_FIRST;
                            end
                        end
                    end
                    PH_COLLECT:
                    begin
                        acc_next = acc_shift;
                        rem_next = rem_dec;
                        if (rem_dec == 3'd0)
                        begin
                            q_push                    = 1'b1;
                            q_entry.res.status        = ST_OK;
                            q_entry.res.packet_tag    = tag_reg;
                            q_entry.res.packet_length = acc_shift;
                            q_entry.res.has_length    = 1'b1;
                        end
                    end
                    PH_NEW_FIRST:
                    begin
                        if (b < LEN_TWO_BYTE_MIN)
                        begin
                            q_push                    = 1'b1;
                            q_entry.res.status        = ST_OK;
                            q_entry.res.packet_tag    = tag_reg;
                            q_entry.res.packet_length = {24'd0, b};
                            q_entry.res.has_length    = 1'b1;
                        end
                        else if (b <= LEN_TWO_BYTE_MAX)
                        begin
                            acc_next   = {24'd0, b};
                            phase_next = PH_NEW_SECOND;
                        end
                        else if (b == LEN_FOUR_BYTE)
                        begin
                            acc_next   = '0;
                            rem_next   = 3'd4;
                            phase_next = PH_COLLECT;
                        end
                        else
                        begin
                            q_push                 = 1'b1;
                            q_entry.res.status     = ST_UNHANDLED;
                            q_entry.res.packet_tag = tag_reg;
                        end
                    end
                    PH_NEW_SECOND:
                    begin
                        q_push                    = 1'b1;
                        q_entry.two_byte          = 1'b1;
                        q_entry.res.status        = ST_OK;
                        q_entry.res.packet_tag    = tag_reg;
                        q_entry.res.packet_length = {19'd0, acc_reg[4:0], b};
                        q_entry.res.has_length    = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end

            if (q_push)
            begin
                phase_next = PH_IDLE;
                rem_next   = '0;
                acc_next   = '0;
                tag_next   = '0;
            end
        end
    end

endmodule

FILE: sv/php_fifo.sv
// ----------------------------------------------------------------------------
// php_fifo
// Small register queue between the header front end and the result stage.
// ----------------------------------------------------------------------------
module php_fifo
    import php_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  php_entry_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output php_entry_t rd_data,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    php_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: sv/php_back.sv
// ----------------------------------------------------------------------------
// php_back
// Result stage: finishes the length and holds the result until it is popped.
// ----------------------------------------------------------------------------
module php_back
    import php_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  php_entry_t q_entry,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output php_out_t   result
);

    logic     valid_reg, valid_next;
    php_out_t result_reg, result_next;

    assign q_pop  = !q_empty && (!valid_reg || pop);
    assign empty  = !valid_reg;
    assign result = result_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        result_next = result_reg;
        if (q_pop)
        begin
            valid_next  = 1'b1;
            result_next = q_entry.res;
            if (q_entry.two_byte)
                result_next.packet_length = q_entry.res.packet_length + LEN_TWO_BYTE_BIAS;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

FILE: sv/packet_header_parser.sv
// ----------------------------------------------------------------------------
// packet_header_parser
// Decodes old- and new-format packet headers from a byte stream.
// ----------------------------------------------------------------------------
// The input side is a queue write port: present in_item and raise push; the
// byte or end-of-stream mark is taken at a clock edge where full is low.
// The output side is a queue read port: while empty is low, result holds the
// oldest decoded header; it is removed at a clock edge where pop is high.
// Every header ends in exactly one result: ok, stream ended early, invalid
// header or unhandled length. After any result the parser expects a new
// header. One input request is taken every cycle while full is low. A request
// that completes a header is written into the queue by the header state
// machine at the accepting edge; the result register loads it from the queue
// when that register is empty or being popped. When pop stays low the result register
// and the queue of QUEUE_DEPTH entries fill, after which full rises and input
// stalls; the state machine never waits otherwise.
// Reset empties the queue and the result register and returns the parser to
// waiting for the first byte of a header.
// ----------------------------------------------------------------------------
module packet_header_parser
    import php_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  php_in_t  in_item,
    output logic     empty,
    input  logic     pop,
    output php_out_t result
);

    logic       accept;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    php_entry_t q_wr_entry;
    php_entry_t q_rd_entry;

    assign full   = q_full;
    assign accept = push && !q_full;

    php_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .q_push  (q_push),
        .q_entry (q_wr_entry)
    );

    php_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_entry),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_entry),
        .empty   (q_empty)
    );

    php_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_entry (q_rd_entry),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("header result queued while the queue is full");

    a_invalid_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == ST_INVALID) |->
        (result.packet_tag == 6'd0 && result.packet_length == 32'd0 && !result.has_length))
        else $error("invalid header result carries tag or length");

    a_length_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.has_length) |-> (result.status == ST_OK))
        else $error("length reported with a non-ok status");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before it was popped");

endmodule
